### hw/rtl/c_subset_lexer_defines.svh
// assertion macros for the lexer
`ifndef C_SUBSET_LEXER_DEFINES_SVH
`define C_SUBSET_LEXER_DEFINES_SVH
`define CSL_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define CSL_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);
`endif

### hw/rtl/csl_pkg.sv
// shared types and constants of the lexer
package csl_pkg;
  localparam logic [2:0] KIND_TEXT = 3'd0;
  localparam logic [2:0] KIND_EOF = 3'd1;
  localparam logic [2:0] KIND_INT = 3'd2;
  localparam logic [2:0] KIND_IDENT = 3'd3;
  localparam logic [2:0] KIND_STR = 3'd4;
  localparam logic [2:0] KIND_OP = 3'd5;
  localparam logic [2:0] KIND_KW = 3'd6;
  localparam logic [2:0] KIND_ERR = 3'd7;
  localparam logic [1:0] ERR_CHAR = 2'd0;
  localparam logic [1:0] ERR_STR = 2'd1;
  localparam logic [1:0] ERR_LIMIT = 2'd2;
  localparam logic [23:0] LINE_MAX = 24'hFFFFFF;

  typedef enum logic [2:0] {
    M_IDLE, M_NUM, M_IDENT, M_STR, M_ESC, M_COMMENT, M_PEND, M_HALT
  } mode_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  text;
    logic [63:0] ival;
    logic [4:0]  op;
    logic [2:0]  kw;
    logic [1:0]  err;
    logic [23:0] line;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t r0;
    res_t r1;
  } step_t;

  function automatic logic [4:0] single_idx(input logic [7:0] c);
    logic [4:0] r;
    begin
      r = 5'd31;
      case (c)
        8'h2B: r = 5'd0;  8'h2D: r = 5'd1;  8'h2A: r = 5'd2;  8'h2F: r = 5'd3;
        8'h25: r = 5'd4;  8'h3D: r = 5'd5;  8'h3C: r = 5'd6;  8'h3E: r = 5'd7;
        8'h21: r = 5'd8;  8'h28: r = 5'd9;  8'h29: r = 5'd10; 8'h7B: r = 5'd11;
        8'h7D: r = 5'd12; 8'h3B: r = 5'd13; 8'h2C: r = 5'd14;
        default: r = 5'd31;
      endcase
      return r;
    end
  endfunction

  function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] p);
    logic [47:0] s;
    begin
      case (k)
        3'd0: s = {24'd0, "tni"};
        3'd1: s = {32'd0, "fi"};
        3'd2: s = {16'd0, "esle"};
        3'd3: s = {8'd0, "elihw"};
        3'd4: s = {8'd0, "tnirp"};
        3'd5: s = "nruter";
        3'd6: s = {16'd0, "niam"};
        default: s = '0;
      endcase
      return s[p*8 +: 8];
    end
  endfunction

  function automatic logic [7:0] kw_len(input logic [2:0] k);
    case (k)
      3'd0: return 8'd3; 3'd1: return 8'd2; 3'd2: return 8'd4; 3'd3: return 8'd5;
      3'd4: return 8'd5; 3'd5: return 8'd6; 3'd6: return 8'd4;
      default: return 8'd0;
    endcase
  endfunction
endpackage

### hw/rtl/csl_core.sv
// lexer state and per-character decision logic
module csl_core import csl_pkg::*; #(
  parameter int TOKEN_LIMIT = 65536,
  parameter int TEXT_MAX = 255
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] char_i,
  output step_t      res_o
);
  localparam logic [17:0] TokLim = 18'(TOKEN_LIMIT);
  localparam logic [7:0]  TxtMax = 8'(TEXT_MAX);

  mode_e mode_q, mode_d;
  logic [7:0] pend_q, pend_d, len_q, len_d;
  logic [63:0] acc_q, acc_d;
  logic [6:0] hits_q, hits_d;
  logic [23:0] line_q, line_d, tline_q, tline_d;
  logic [17:0] cnt_q, cnt_d;
  step_t s;

  function automatic logic is_sp(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction
  function automatic logic is_dg(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic logic is_al(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  always_comb begin
    logic [7:0] c, t;
    logic [4:0] idx;
    logic [4:0] pr;
    logic do_start, fail_on;
    logic [1:0] fcode;
    res_t r;
    c = char_i;
    mode_d = mode_q; pend_d = pend_q; len_d = len_q; acc_d = acc_q;
    hits_d = hits_q; line_d = line_q; tline_d = tline_q; cnt_d = cnt_q;
    s = '0;
    do_start = 1'b0; fail_on = 1'b0; fcode = ERR_CHAR;
    t = c; idx = 5'd0; pr = 5'd31;
    r = '0;
    unique case (mode_q)
      M_IDLE: do_start = 1'b1;
      M_NUM: begin
        if (is_dg(c)) begin
          acc_d = (acc_q << 3) + (acc_q << 1) + 64'(c - "0");
        end else begin
          r = '0; r.kind = KIND_INT; r.ival = acc_q; r.line = tline_q;
          s.r0 = r; s.n = 2'd1; cnt_d = cnt_q + 18'd1; do_start = 1'b1;
        end
      end
      M_IDENT: begin
        if ((is_al(c) || is_dg(c)) && len_q < TxtMax) begin
          for (int k = 0; k < 7; k++)
            if (len_q >= kw_len(3'(k)) || kw_char(3'(k), len_q[2:0]) != c)
              hits_d[k] = 1'b0;
          len_d = len_q + 8'd1;
          r = '0; r.kind = KIND_TEXT; r.text = c; r.line = tline_q;
          s.r0 = r; s.n = 2'd1;
        end else begin
          r = '0; r.kind = KIND_IDENT; r.line = tline_q;
          for (int k = 0; k < 7; k++)
            if (hits_q[k] && kw_len(3'(k)) == len_q) begin
              r.kind = KIND_KW; r.kw = 3'(k);
            end
          s.r0 = r; s.n = 2'd1; cnt_d = cnt_q + 18'd1; do_start = 1'b1;
        end
      end
      M_STR: begin
        if (len_q >= TxtMax) begin
          if (c == 8'h22) begin
            r = '0; r.kind = KIND_STR; r.line = tline_q; s.r0 = r; s.n = 2'd1;
            cnt_d = cnt_q + 18'd1; mode_d = M_IDLE;
          end else begin
            fail_on = 1'b1; fcode = ERR_STR;
          end
        end else if (c == 8'h00) begin
          fail_on = 1'b1; fcode = ERR_STR;
        end else if (c == 8'h22) begin
          r = '0; r.kind = KIND_STR; r.line = tline_q; s.r0 = r; s.n = 2'd1;
          cnt_d = cnt_q + 18'd1; mode_d = M_IDLE;
        end else if (c == 8'h5C) begin
          mode_d = M_ESC;
        end else begin
          r = '0; r.kind = KIND_TEXT; r.text = c; r.line = tline_q; s.r0 = r; s.n = 2'd1;
          len_d = len_q + 8'd1;
        end
      end
      M_ESC: begin
        if (c == 8'h00) begin
          fail_on = 1'b1; fcode = ERR_STR;
        end else begin
          if (c == "n") t = 8'h0A;
          else if (c == "t") t = 8'h09;
          r = '0; r.kind = KIND_TEXT; r.text = t; r.line = tline_q; s.r0 = r; s.n = 2'd1;
          len_d = len_q + 8'd1; mode_d = M_STR;
        end
      end
      M_COMMENT: begin
        if (c == 8'h00) do_start = 1'b1;
        else if (c == 8'h0A) begin
          if (line_q < LINE_MAX) line_d = line_q + 24'd1;
          mode_d = M_IDLE;
        end
      end
      M_PEND: begin
        if (c == "=") begin
          case (pend_q)
            "=": pr = 5'd15; "!": pr = 5'd16; "<": pr = 5'd17; ">": pr = 5'd18;
            default: pr = 5'd31;
          endcase
        end else if (c == "&" && pend_q == "&") pr = 5'd19;
        else if (c == "|" && pend_q == "|") pr = 5'd20;
        idx = single_idx(pend_q);
        if (pr != 5'd31) begin
          r = '0; r.kind = KIND_OP; r.op = pr; r.line = tline_q; s.r0 = r; s.n = 2'd1;
          cnt_d = cnt_q + 18'd1; mode_d = M_IDLE;
        end else if (pend_q == "/" && c == "/") begin
          mode_d = M_COMMENT;
        end else if (pend_q == "/" && cnt_q >= TokLim) begin
          fail_on = 1'b1; fcode = ERR_LIMIT;
        end else if (idx == 5'd31) begin
          fail_on = 1'b1; fcode = ERR_CHAR;
        end else begin
          r = '0; r.kind = KIND_OP; r.op = idx; r.line = tline_q; s.r0 = r; s.n = 2'd1;
          cnt_d = cnt_q + 18'd1; do_start = 1'b1;
        end
      end
      M_HALT: ;
      default: ;
    endcase

    if (do_start) begin
      mode_d = M_IDLE;
      r = '0;
      if (c == 8'h00) begin
        r.kind = KIND_EOF; r.line = line_q;
        mode_d = M_IDLE; pend_d = '0; acc_d = '0; len_d = '0; hits_d = '1;
        line_d = 24'd1; tline_d = 24'd1; cnt_d = '0;
      end else if (c == 8'h0A) begin
        if (line_q < LINE_MAX) line_d = line_q + 24'd1;
      end else if (!is_sp(c)) begin
        tline_d = line_q;
        idx = single_idx(c);
        if (c == "/") begin
          mode_d = M_PEND; pend_d = c;
        end else if (cnt_d >= TokLim) begin
          fail_on = 1'b1; fcode = ERR_LIMIT;
        end else if (is_dg(c)) begin
          mode_d = M_NUM; acc_d = 64'(c - "0");
        end else if (is_al(c)) begin
          mode_d = M_IDENT; len_d = 8'd1;
          for (int k = 0; k < 7; k++)
            hits_d[k] = (kw_char(3'(k), 3'd0) == c);
          r.kind = KIND_TEXT; r.text = c; r.line = line_q;
        end else if (c == 8'h22) begin
          mode_d = M_STR; len_d = '0;
        end else if (c == "=" || c == "!" || c == "<" || c == ">" || c == "&"
                     || c == "|") begin
          mode_d = M_PEND; pend_d = c;
        end else if (idx != 5'd31) begin
          r.kind = KIND_OP; r.op = idx; r.line = line_q; cnt_d = cnt_d + 18'd1;
        end else begin
          fail_on = 1'b1; fcode = ERR_CHAR;
        end
      end
      if (c == 8'h00 || (!fail_on && (mode_d == M_IDENT
          || (r.kind == KIND_OP && r.line == line_q && mode_d == M_IDLE
              && c != 8'h0A && !is_sp(c))))) begin
        if (s.n == 2'd0) begin s.r0 = r; s.n = 2'd1; end
        else begin s.r1 = r; s.n = 2'd2; end
      end
    end

    if (fail_on) begin
      r = '0; r.kind = KIND_ERR; r.err = fcode; r.line = line_q;
      if (s.n == 2'd0) begin s.r0 = r; s.n = 2'd1; end
      else begin s.r1 = r; s.n = 2'd2; end
      mode_d = M_HALT;
    end
  end

  assign res_o = s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE; pend_q <= '0; acc_q <= '0; len_q <= '0; hits_q <= '1;
      line_q <= 24'd1; tline_q <= 24'd1; cnt_q <= '0;
    end else if (step_i) begin
      mode_q <= mode_d; pend_q <= pend_d; acc_q <= acc_d; len_q <= len_d;
      hits_q <= hits_d; line_q <= line_d; tline_q <= tline_d; cnt_q <= cnt_d;
    end
  end
endmodule

### hw/rtl/csl_outq.sv
// result queue that hands out up to two results per request
module csl_outq import csl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  step_t       step_i,
  output logic        space_o,
  output logic        valid_o,
  input  logic        ready_i,
  output res_t        res_o,
  output logic        last_o
);
  res_t r0_q, r1_q;
  logic [1:0] n_q;
  logic pop;
  assign pop = valid_o && ready_i;
  assign valid_o = n_q != 2'd0;
  assign res_o = r0_q;
  assign last_o = n_q == 2'd1;
  assign space_o = n_q == 2'd0 || (n_q == 2'd1 && pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= '0;
    end else if (push_i && step_i.n != 2'd0) begin
      n_q <= step_i.n;
    end else if (pop) begin
      n_q <= n_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && step_i.n != 2'd0) begin
      r0_q <= step_i.r0;
      r1_q <= step_i.r1;
    end else if (pop) begin
      r0_q <= r1_q;
    end
  end

  `include "c_subset_lexer_defines.svh"
  `CSL_ASSERT(a_push_room, clk_i, rst_ni, !(push_i && step_i.n != 2'd0) || space_o, "push overflow")
  `CSL_ASSERT(a_n_range, clk_i, rst_ni, n_q != 2'd3, "bad count")
  `CSL_ASSERT_NEXT(a_pop_dec, clk_i, rst_ni, pop && n_q == 2'd2 && !push_i, n_q == 2'd1, "pop lost")
endmodule

### hw/rtl/c_subset_lexer.sv
// top level of the streaming lexer
// channel | dir | signals
// input   | in  | char_valid_i char_ready_o char_byte_i
// result  | out | res_valid_o res_ready_i result_kind_o .. last_of_run_o
// one character per cycle while char_ready_o is high; each request gives zero to two results
// results of a request are held in a two-entry queue and leave one a cycle while res_ready_i is high
// a new request is taken when the queue is empty or while its last result is being taken
// reset returns all lexer state to its start values and empties the queue
module c_subset_lexer import csl_pkg::*; #(
  parameter int TOKEN_LIMIT = 65536,
  parameter int TEXT_MAX = 255
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               char_valid_i,
  output logic               char_ready_o,
  input  logic [7:0]         char_byte_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output logic [2:0]         result_kind_o,
  output logic [7:0]         text_byte_o,
  output logic signed [63:0] int_value_o,
  output logic [4:0]         op_code_o,
  output logic [2:0]         keyword_index_o,
  output logic [1:0]         error_code_o,
  output logic [23:0]        line_number_o,
  output logic               last_of_run_o
);
  step_t st;
  res_t r;
  logic acc;
  assign acc = char_valid_i && char_ready_o;

  csl_core #(.TOKEN_LIMIT(TOKEN_LIMIT), .TEXT_MAX(TEXT_MAX)) u_core (
    .clk_i, .rst_ni, .step_i(acc), .char_i(char_byte_i), .res_o(st)
  );
  csl_outq u_q (
    .clk_i, .rst_ni, .push_i(acc), .step_i(st), .space_o(char_ready_o),
    .valid_o(res_valid_o), .ready_i(res_ready_i), .res_o(r), .last_o(last_of_run_o)
  );
  assign result_kind_o = r.kind;
  assign text_byte_o = r.text;
  assign int_value_o = r.ival;
  assign op_code_o = r.op;
  assign keyword_index_o = r.kw;
  assign error_code_o = r.err;
  assign line_number_o = r.line;
endmodule
